// ===== src/fprs_pkg.sv =====
// Shared constants and types for the five-point raster smoother.
// Used by fprs_div and five_point_raster_smoother_core; depends on nothing.
`default_nettype none

package fprs_pkg;

    // raster geometry (MAX_COLS is a power of two)
    localparam int MAX_COLS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = COL_W + 1;
    localparam int ROW_W      = 16;
    localparam int NUM_COLS_W = 11;

    // sample and accumulator widths
    localparam int DATA_W = 32;
    localparam int SUM_W  = DATA_W + 3;
    localparam int WT_W   = 3;

    // divider: a few quotient bits per cycle
    localparam int DIV_BITS  = 4;
    localparam int MAG_W     = ((SUM_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_CYC   = MAG_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

    // row counter saturation: wraps to a value with the same parity and >= 2
    localparam logic [ROW_W-1:0] ROW_MAX  = '1;
    localparam logic [ROW_W-1:0] ROW_WRAP = ROW_W'(2);

    // command codes carried in tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA   = 1'b1;

    // configuration reset values
    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = NUM_COLS_W'(100);
    localparam logic [DATA_W-1:0]     NODATA_RST   = 32'hD8F1_0000;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [WT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/fprs_div.sv =====
// Signed by small unsigned divider, truncating toward zero, DIV_BITS quotient
// bits per cycle. Depends on fprs_pkg.
`default_nettype none

module fprs_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire fprs_pkg::div_req_t req,
    output fprs_pkg::div_rsp_t      rsp
);
    import fprs_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [WT_W-1:0]      rem_reg;
    logic [WT_W-1:0]      den_reg;

    logic [MAG_W-1:0] mag_next;
    logic [WT_W-1:0]  rem_next;
    logic [WT_W:0]    trial;
    logic [MAG_W-1:0] dividend_x;
    logic [MAG_W-1:0] q_signed;

    // sign-extend dividend so its magnitude can be taken without overflow
    assign dividend_x = {{(MAG_W-SUM_W){req.dividend[SUM_W-1]}}, req.dividend};

    // restoring steps: remainder stays below the divisor, so it is narrow
    always_comb begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial    = {rem_next, mag_next[MAG_W-1]};
            mag_next = {mag_next[MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                trial       = trial - {1'b0, den_reg};
                mag_next[0] = 1'b1;
            end
            rem_next = trial[WT_W-1:0];
        end
    end

    // quotient bits have replaced the dividend once all steps are done
    assign q_signed     = neg_reg ? (~mag_reg + MAG_W'(1)) : mag_reg;
    assign rsp.quotient = q_signed[DATA_W-1:0];
    assign rsp.done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYC);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg <= req.dividend[SUM_W-1];
            mag_reg <= req.dividend[SUM_W-1] ? (~dividend_x + MAG_W'(1)) : dividend_x;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end else if (busy_reg) begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/five_point_raster_smoother_core.sv =====
// Top level of the five-point raster smoother: line store, read sequencer,
// accumulator and output register. Depends on fprs_pkg and fprs_div.
`default_nettype none

// Smooths a row-major Q16.16 raster: each result is (2*centre + east + west +
// north + south) divided by the summed weight, truncated toward zero, with
// nodata neighbours skipped and a nodata centre passed through as nodata.
// Columns wrap, top and bottom rows reflect to the inner row. Row r comes out
// while row r+1 streams in; flush beats (tuser = 1) emit the last row, with
// tuser set on the final pixel. Two rows live in one single-port-read line
// store of 2*MAX_COLS words. A beat that produces a result makes four
// line-store reads through the one read port, runs the 4-bit-per-cycle
// divider and loads the output once the output register is free; one that
// produces none (first row, flush with no row) stays in idle. The next input
// beat is taken while a result still waits in the output register. Configuration
// writes are accepted at any time and must only be issued while idle.
module five_point_raster_smoother_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [fprs_pkg::DATA_W-1:0]         s_tdata,   // [31:0] sample
    input  wire logic [0:0]                          s_tuser,   // [0] cmd
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [fprs_pkg::DATA_W-1:0]              m_tdata,   // [31:0] smoothed
    output logic                                     m_tlast,   // end_of_row
    output logic [0:0]                               m_tuser,   // [0] end_of_frame
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fprs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fprs_pkg::DATA_W-1:0]         cfg_data
);
    import fprs_pkg::*;

    localparam int                NUM_TAPS  = 4;
    localparam int                STEP_W    = $clog2(NUM_TAPS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_TAPS);
    // tap slots in read order
    localparam logic [1:0] SLOT_CTR = 2'd2;
    localparam logic [1:0] SLOT_VRT = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_DIV,
        S_OUT
    } state_t;

    // weighted, nodata-masked contribution of one sample
    function automatic logic [SUM_W-1:0] weigh(
        input logic [DATA_W-1:0] v,
        input logic [1:0]        w,
        input logic [DATA_W-1:0] nd
    );
        logic [SUM_W-1:0] sx;
        sx = {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
        if (v == nd) begin
            return '0;
        end
        case (w)
            2'd1:    return sx;
            2'd2:    return {sx[SUM_W-2:0], 1'b0};
            default: return '0;
        endcase
    endfunction

    // configuration
    logic [NUM_COLS_W-1:0] num_cols_reg;
    logic [DATA_W-1:0]     nodata_reg;

    // frame position
    logic [ROW_W-1:0] row_count_reg, row_next;
    logic [COL_W-1:0] col_count_reg, col_next;
    logic [COL_W-1:0] flush_col_reg, flush_next;

    // per-beat work registers
    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [ADDR_W-1:0]   rd_addr_reg [NUM_TAPS];
    logic [1:0]          n_wt_reg;
    logic                is_pix_reg;
    logic                eor_reg;
    logic                eof_reg;
    logic                ctr_nd_reg;
    logic [ADDR_W-1:0]   wr_addr_reg;
    logic [DATA_W-1:0]   smp_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [WT_W-1:0]     wt_reg;

    // output register
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    // line store
    logic [DATA_W-1:0] line_store [2*MAX_COLS];
    logic [DATA_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // accept-time decode
    logic              accept;
    logic              is_pix;
    logic              abandon;
    logic [ROW_W-1:0]  row_e;
    logic [COL_W-1:0]  c_sel;
    logic [COL_W-1:0]  nm1;
    logic              last;
    logic              has_out;
    logic [COL_W-1:0]  east_col;
    logic [COL_W-1:0]  west_col;
    logic              bank_h;
    logic              bank_v;
    logic [1:0]        n_wt;
    logic [1:0]        s_wt;
    logic              smp_nd;

    // capture-time terms
    logic [1:0]        slot;
    logic [1:0]        slot_wt;
    logic              rd_nd;
    logic              out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // last column index of a row, num_cols clamped to 2..MAX_COLS
    always_comb begin
        if (num_cols_reg < NUM_COLS_W'(2)) begin
            nm1 = COL_W'(1);
        end else if (32'(num_cols_reg) > 32'(MAX_COLS)) begin
            nm1 = COL_W'(MAX_COLS - 1);
        end else begin
            nm1 = COL_W'(num_cols_reg - NUM_COLS_W'(1));
        end
    end

    // decode the incoming beat and step the frame position
    always_comb begin
        is_pix   = (s_tuser[0] == CMD_PIXEL);
        abandon  = is_pix && (flush_col_reg != '0);
        row_e    = abandon ? '0 : row_count_reg;
        c_sel    = is_pix ? (abandon ? '0 : col_count_reg) : flush_col_reg;
        last     = (c_sel >= nm1);
        has_out  = (row_e != '0);
        east_col = last ? '0 : c_sel + COL_W'(1);
        west_col = (c_sel == '0) ? nm1 : c_sel - COL_W'(1);
        bank_h   = ~row_e[0];
        bank_v   = row_e[0];
        smp_nd   = (s_tdata == nodata_reg);
        if (is_pix) begin
            n_wt       = (row_e == ROW_W'(1)) ? 2'd0 : 2'd1;
            s_wt       = (row_e == ROW_W'(1)) ? 2'd2 : 2'd1;
            col_next   = last ? '0 : c_sel + COL_W'(1);
            flush_next = '0;
            if (!last) begin
                row_next = row_e;
            end else if (row_e == ROW_MAX) begin
                row_next = ROW_WRAP;
            end else begin
                row_next = row_e + ROW_W'(1);
            end
        end else begin
            n_wt     = (row_e >= ROW_W'(2)) ? 2'd2 : 2'd0;
            s_wt     = 2'd0;
            col_next = '0;
            if (!has_out || last) begin
                row_next   = '0;
                flush_next = '0;
            end else begin
                row_next   = row_e;
                flush_next = c_sel + COL_W'(1);
            end
        end
    end

    // line store access: write the sample once its column has been read
    always_comb begin
        mem_raddr = rd_addr_reg[step_reg[1:0]];
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = smp_reg;
        if (accept && is_pix && !has_out) begin
            mem_we    = 1'b1;
            mem_waddr = {bank_v, c_sel};
            mem_wdata = s_tdata;
        end else if (state_reg == S_READ && step_reg == STEP_LAST && is_pix_reg) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_store[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= line_store[mem_raddr];
    end

    // weight of the tap whose data arrives this cycle
    always_comb begin
        slot = step_reg[1:0] - 2'd1;
        case (slot)
            SLOT_CTR: slot_wt = 2'd2;
            SLOT_VRT: slot_wt = n_wt_reg;
            default:  slot_wt = 2'd1;
        endcase
        rd_nd = (mem_rdata_reg == nodata_reg);
    end

    // divider
    assign div_req.start    = (state_reg == S_START);
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = wt_reg;

    fprs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer, frame counters, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            col_count_reg <= '0;
            flush_col_reg <= '0;
            step_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            num_cols_reg  <= NUM_COLS_RST;
            nodata_reg    <= NODATA_RST;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_NUM_COLS: num_cols_reg <= cfg_data[NUM_COLS_W-1:0];
                    CFG_NODATA:   nodata_reg   <= cfg_data;
                    default:      num_cols_reg <= num_cols_reg;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        row_count_reg  <= row_next;
                        col_count_reg  <= col_next;
                        flush_col_reg  <= flush_next;
                        rd_addr_reg[0] <= {bank_h, east_col};
                        rd_addr_reg[1] <= {bank_h, west_col};
                        rd_addr_reg[2] <= {bank_h, c_sel};
                        rd_addr_reg[3] <= {bank_v, c_sel};
                        n_wt_reg       <= n_wt;
                        is_pix_reg     <= is_pix;
                        eor_reg        <= last;
                        eof_reg        <= !is_pix && last;
                        ctr_nd_reg     <= 1'b0;
                        wr_addr_reg    <= {bank_v, c_sel};
                        smp_reg        <= s_tdata;
                        sum_reg        <= weigh(s_tdata, s_wt, nodata_reg);
                        wt_reg         <= smp_nd ? '0 : WT_W'(s_wt);
                        step_reg       <= '0;
                        if (has_out) begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // accumulate the tap read in the previous cycle
                    if (step_reg != '0) begin
                        sum_reg <= sum_reg + weigh(mem_rdata_reg, slot_wt, nodata_reg);
                        wt_reg  <= wt_reg + (rd_nd ? '0 : WT_W'(slot_wt));
                        if (slot == SLOT_CTR) begin
                            ctr_nd_reg <= rd_nd;
                        end
                    end
                    if (step_reg == STEP_LAST) begin
                        state_reg <= S_START;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_START: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= ctr_nd_reg ? nodata_reg : div_rsp.quotient;
                        m_tlast_reg  <= eor_reg;
                        m_tuser_reg  <= eof_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    // a partial row and an unfinished flush never coexist
    a_col_flush_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !((col_count_reg != '0) && (flush_col_reg != '0)))
        else $error("column and flush counters both active");

    // a real centre always brings a divisor of 2 to 6
    a_div_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_START && !ctr_nd_reg) |-> (wt_reg >= WT_W'(2) && wt_reg <= WT_W'(6)))
        else $error("divisor out of range at divide start");

    // the end-of-frame beat leaves the frame counters cleared
    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free && eof_reg)
            |=> (row_count_reg == '0 && flush_col_reg == '0))
        else $error("frame counters not cleared after last flush pixel");

    // the divider only answers while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
